// ----- hdl/pqm_pkg.sv -----
`default_nettype none

package pqm_pkg;

    // Field widths fixed by the request and response formats
    localparam int ID_W   = 6;
    localparam int REQ_W  = 3;
    localparam int LSEL_W = 3;
    localparam int LIST_W = 3;
    localparam int ST_W   = 2;

    localparam logic [ID_W-1:0]   ID_MAX    = 6'd63;
    localparam logic [LIST_W-1:0] LIST_EXEC = 3'd0;
    localparam logic [LIST_W-1:0] LIST_NONE = 3'd5;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_UNLINK = 3'd2,
        REQ_SETCUR = 3'd3,
        REQ_NEXT   = 3'd4,
        REQ_LOOKUP = 3'd5
    } t_req;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LIST = 2'd1,
        ST_BAD_ID   = 2'd2
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hdl/pqm_ifs.sv -----
`default_nettype none

interface pqm_req_if;
    logic                         valid;
    logic                         ready;
    logic [pqm_pkg::REQ_W-1:0]    req_type;
    logic [pqm_pkg::ID_W-1:0]     proc_id;
    logic [pqm_pkg::LSEL_W-1:0]   list_sel;
    logic                         include_self;

    modport source (output valid, req_type, proc_id, list_sel, include_self, input ready);
    modport sink   (input valid, req_type, proc_id, list_sel, include_self, output ready);
endinterface

interface pqm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pqm_pkg::ID_W-1:0]     result_id;
    logic                         found;
    logic [pqm_pkg::LIST_W-1:0]   list_of;
    logic [pqm_pkg::ST_W-1:0]     status;
    logic [pqm_pkg::ID_W-1:0]     proc_count;

    modport source (output valid, result_id, found, list_of, status, proc_count, input ready);
    modport sink   (input valid, result_id, found, list_of, status, proc_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/pqm_ctrl.sv -----
`default_nettype none

module pqm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output pqm_pkg::t_dp_cmd      o_cmd,
    input  wire pqm_pkg::t_dp_sts i_sts
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, commit;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = o_req_ready && i_req_valid;
    // Retire only when the output slot is free or being emptied this cycle
    assign commit      = (r_state == S_EXEC) && (!r_out_valid || i_rsp_ready);
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        o_cmd.clear  = (r_state == S_CLEAR);
        o_cmd.accept = accept;
        o_cmd.commit = commit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pqm_datapath.sv -----
`default_nettype none

module pqm_datapath #(
    parameter int MAX_PROCS = 64,
    parameter int NUM_LISTS = 5
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire pqm_pkg::t_dp_cmd             i_cmd,
    output pqm_pkg::t_dp_sts                  o_sts,
    input  wire logic                         i_cfg_we,
    input  wire logic [pqm_pkg::ID_W-1:0]     i_cfg_wdata,
    input  wire logic [pqm_pkg::REQ_W-1:0]    i_req_type,
    input  wire logic [pqm_pkg::ID_W-1:0]     i_proc_id,
    input  wire logic [pqm_pkg::LSEL_W-1:0]   i_list_sel,
    input  wire logic                         i_include_self,
    output logic [pqm_pkg::ID_W-1:0]          o_result_id,
    output logic                              o_found,
    output logic [pqm_pkg::LIST_W-1:0]        o_list_of,
    output logic [pqm_pkg::ST_W-1:0]          o_status,
    output logic [pqm_pkg::ID_W-1:0]          o_proc_count
);

    localparam int IW  = $clog2(MAX_PROCS);
    localparam int LXW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_PROCS - 1);

    // Per-process memories
    logic [IW-1:0]                  r_next_mem [MAX_PROCS];
    logic [IW-1:0]                  r_prev_mem [MAX_PROCS];
    logic [pqm_pkg::LIST_W-1:0]     r_memb_mem [MAX_PROCS];

    // Per-list registers
    logic [IW-1:0]                  r_head [NUM_LISTS];
    logic [IW-1:0]                  r_tail [NUM_LISTS];
    logic [NUM_LISTS-1:0]           r_nonempty;

    logic [pqm_pkg::ID_W-1:0]       r_current;
    logic [pqm_pkg::ID_W-1:0]       r_idle_pid;
    logic [CW-1:0]                  r_id_cnt;
    logic [CW-1:0]                  r_linked, n_linked;
    logic [IW-1:0]                  r_clr_addr;

    // Latched request and registered read data
    logic [pqm_pkg::REQ_W-1:0]      r_req;
    logic [pqm_pkg::ID_W-1:0]       r_pid;
    logic [pqm_pkg::LSEL_W-1:0]     r_sel;
    logic                           r_inc;
    logic [IW-1:0]                  r_nl_q;
    logic [IW-1:0]                  r_pl_q;
    logic [pqm_pkg::LIST_W-1:0]     r_ml_q;

    logic [IW-1:0]                  rd_addr;

    // Execute-stage decode
    logic [pqm_pkg::ID_W-1:0]       n_res;
    logic                           n_found;
    logic [pqm_pkg::LIST_W-1:0]     n_lst;
    logic [pqm_pkg::ST_W-1:0]       n_status;
    logic                           nl_we, pl_we, ml_we;
    logic [IW-1:0]                  nl_addr, nl_data, pl_addr, pl_data;
    logic [pqm_pkg::LIST_W-1:0]     ml_data;
    logic                           head_we, tail_we, ne_set, ne_clr;
    logic [LXW-1:0]                 w_lidx;
    logic [IW-1:0]                  head_data, tail_data;
    logic                           cur_we, idc_inc, cnt_inc, cnt_dec;

    logic                           pid_ok, sel_ok, cur_ok;
    logic [IW-1:0]                  p_addr, c_addr;
    logic [LXW-1:0]                 sel_idx, memb_idx, exec_idx;
    logic                           is_head, is_tail;

    assign o_sts.clear_last = i_cmd.clear && (r_clr_addr == LAST_ADDR);

    // Next reads at the current process, everything else at the request id
    assign rd_addr = (i_req_type == pqm_pkg::REQ_NEXT) ? IW'(r_current) : IW'(i_proc_id);

    assign pid_ok   = (32'(r_pid) < MAX_PROCS);
    assign cur_ok   = (32'(r_current) < MAX_PROCS);
    assign sel_ok   = (32'(r_sel) < NUM_LISTS);
    assign p_addr   = IW'(r_pid);
    assign c_addr   = IW'(r_current);
    assign sel_idx  = LXW'(r_sel);
    assign memb_idx = LXW'(r_ml_q);
    assign exec_idx = LXW'(pqm_pkg::LIST_EXEC);
    assign is_head  = (r_head[memb_idx] == p_addr);
    assign is_tail  = (r_tail[memb_idx] == p_addr);

    always_comb begin
        n_res     = r_pid;
        n_found   = 1'b0;
        n_lst     = pqm_pkg::LIST_NONE;
        n_status  = pqm_pkg::ST_OK;
        nl_we     = 1'b0;
        nl_addr   = r_pl_q;
        nl_data   = r_nl_q;
        pl_we     = 1'b0;
        pl_addr   = r_nl_q;
        pl_data   = r_pl_q;
        ml_we     = 1'b0;
        ml_data   = pqm_pkg::LIST_NONE;
        head_we   = 1'b0;
        tail_we   = 1'b0;
        ne_set    = 1'b0;
        ne_clr    = 1'b0;
        w_lidx    = memb_idx;
        head_data = r_nl_q;
        tail_data = r_pl_q;
        cur_we    = 1'b0;
        idc_inc   = 1'b0;
        cnt_inc   = 1'b0;
        cnt_dec   = 1'b0;
        unique case (r_req)
            pqm_pkg::REQ_CREATE: begin
                if (32'(r_id_cnt) < MAX_PROCS) begin
                    n_res   = pqm_pkg::ID_W'(r_id_cnt);
                    idc_inc = 1'b1;
                end else begin
                    n_res    = '0;
                    n_status = pqm_pkg::ST_BAD_ID;
                end
            end
            pqm_pkg::REQ_APPEND: begin
                if (!sel_ok) begin
                    n_status = pqm_pkg::ST_BAD_LIST;
                end else if (!pid_ok || r_ml_q != pqm_pkg::LIST_NONE) begin
                    n_status = pqm_pkg::ST_BAD_ID;
                end else begin
                    w_lidx    = sel_idx;
                    tail_we   = 1'b1;
                    tail_data = p_addr;
                    ml_we     = 1'b1;
                    ml_data   = pqm_pkg::LIST_W'(r_sel);
                    cnt_inc   = 1'b1;
                    if (r_nonempty[sel_idx]) begin
                        nl_we   = 1'b1;
                        nl_addr = r_tail[sel_idx];
                        nl_data = p_addr;
                        pl_we   = 1'b1;
                        pl_addr = p_addr;
                        pl_data = r_tail[sel_idx];
                    end else begin
                        head_we   = 1'b1;
                        head_data = p_addr;
                        ne_set    = 1'b1;
                    end
                end
            end
            pqm_pkg::REQ_UNLINK: begin
                if (!pid_ok || r_ml_q == pqm_pkg::LIST_NONE) begin
                    n_status = pqm_pkg::ST_BAD_ID;
                end else begin
                    ml_we   = 1'b1;
                    cnt_dec = 1'b1;
                    if (is_head && is_tail) begin
                        ne_clr = 1'b1;
                    end else if (is_head) begin
                        head_we = 1'b1;
                    end else if (is_tail) begin
                        tail_we = 1'b1;
                    end else begin
                        // Bridge the neighbors around the removed node
                        nl_we = 1'b1;
                        pl_we = 1'b1;
                    end
                end
            end
            pqm_pkg::REQ_SETCUR: begin
                if (pid_ok) begin
                    cur_we = 1'b1;
                end else begin
                    n_status = pqm_pkg::ST_BAD_ID;
                end
            end
            pqm_pkg::REQ_NEXT: begin
                if (r_current == r_idle_pid || !cur_ok || r_ml_q != pqm_pkg::LIST_EXEC) begin
                    n_res = r_nonempty[exec_idx] ? pqm_pkg::ID_W'(r_head[exec_idx])
                                                 : r_idle_pid;
                end else if (r_tail[exec_idx] == c_addr) begin
                    if (r_head[exec_idx] == c_addr) begin
                        n_res = r_inc ? r_current : r_idle_pid;
                    end else begin
                        n_res = pqm_pkg::ID_W'(r_head[exec_idx]);
                    end
                end else begin
                    n_res = pqm_pkg::ID_W'(r_nl_q);
                end
            end
            pqm_pkg::REQ_LOOKUP: begin
                if (pid_ok) n_lst = r_ml_q;
                n_found = (r_pid == r_idle_pid) || (n_lst != pqm_pkg::LIST_NONE);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_linked = r_linked;
        if (cnt_inc) begin
            n_linked = r_linked + CW'(1);
        end else if (cnt_dec) begin
            n_linked = r_linked - CW'(1);
        end
    end

    // Memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_nl_q <= r_next_mem[rd_addr];
            r_pl_q <= r_prev_mem[rd_addr];
            r_ml_q <= r_memb_mem[rd_addr];
        end
        if (i_cmd.commit && nl_we) r_next_mem[nl_addr] <= nl_data;
        if (i_cmd.commit && pl_we) r_prev_mem[pl_addr] <= pl_data;
        if (i_cmd.clear) begin
            r_memb_mem[r_clr_addr] <= pqm_pkg::LIST_NONE;
        end else if (i_cmd.commit && ml_we) begin
            r_memb_mem[p_addr] <= ml_data;
        end
    end

    // Request latch, list pointers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_pid <= i_proc_id;
            r_sel <= i_list_sel;
            r_inc <= i_include_self;
        end
        if (i_cmd.commit && head_we) r_head[w_lidx] <= head_data;
        if (i_cmd.commit && tail_we) r_tail[w_lidx] <= tail_data;
        if (i_cmd.commit) begin
            o_result_id  <= n_res;
            o_found      <= n_found;
            o_list_of    <= n_lst;
            o_status     <= n_status;
            o_proc_count <= (32'(n_linked) > 32'(pqm_pkg::ID_MAX)) ? pqm_pkg::ID_MAX
                                                                   : pqm_pkg::ID_W'(n_linked);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            r_current  <= '0;
            r_idle_pid <= '0;
            r_id_cnt   <= '0;
            r_linked   <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) r_idle_pid <= i_cfg_wdata;
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + IW'(1);
            if (i_cmd.commit) begin
                if (ne_set) r_nonempty[w_lidx] <= 1'b1;
                if (ne_clr) r_nonempty[w_lidx] <= 1'b0;
                if (cur_we) r_current <= r_pid;
                if (idc_inc) r_id_cnt <= r_id_cnt + CW'(1);
                r_linked <= n_linked;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/process_queue_manager.sv -----
// Process queue manager: five doubly linked lists of process ids (exec, delay,
// wait, tty read, tty write) kept in per-process link and membership memories.
// The accept cycle reads the link and membership memories (registered read);
// the execute state decides, writes them back and loads the response register
// once the output register is free or being emptied. A new request is taken
// while the previous response still waits in the output register. After reset
// the membership memory is swept to "no list" one entry per cycle; no request is
// accepted during the sweep, and idle_pid writes are taken at any time.
`default_nettype none

module process_queue_manager #(
    parameter int MAX_PROCS = 64,
    parameter int NUM_LISTS = 5
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [pqm_pkg::ID_W-1:0] i_cfg_wdata,
    pqm_req_if.sink                       i_req,
    pqm_rsp_if.source                     o_rsp
);

    pqm_pkg::t_dp_cmd cmd;
    pqm_pkg::t_dp_sts sts;

    pqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    pqm_datapath #(
        .MAX_PROCS (MAX_PROCS),
        .NUM_LISTS (NUM_LISTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_req.req_type),
        .i_proc_id      (i_req.proc_id),
        .i_list_sel     (i_req.list_sel),
        .i_include_self (i_req.include_self),
        .o_result_id    (o_rsp.result_id),
        .o_found        (o_rsp.found),
        .o_list_of      (o_rsp.list_of),
        .o_status       (o_rsp.status),
        .o_proc_count   (o_rsp.proc_count)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import pqm_pkg::*;

    localparam int MAX_IDS   = 64;
    localparam int NUM_LISTS = 5;
    localparam int HOLD_LEN  = 400;

    localparam logic [REQ_W-1:0]  REQ_UNDEF6  = 3'd6;
    localparam logic [REQ_W-1:0]  REQ_UNDEF7  = 3'd7;
    localparam logic [LSEL_W-1:0] LIST_DELAY  = 3'd1;
    localparam logic [LSEL_W-1:0] LIST_WAIT   = 3'd2;
    localparam logic [LSEL_W-1:0] LIST_TTYRD  = 3'd3;
    localparam logic [LSEL_W-1:0] LIST_TTYWR  = 3'd4;
    localparam logic [LSEL_W-1:0] LSEL_BAD_LO = 3'd5;
    localparam logic [LSEL_W-1:0] LSEL_BAD_HI = 3'd7;

    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_EMPTY} t_mix;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [ID_W-1:0]   pid;
        logic [LSEL_W-1:0] sel;
        logic              inc;
    } t_item;

    typedef struct {
        logic [ID_W-1:0]   result_id;
        logic              found;
        logic [LIST_W-1:0] list_of;
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   proc_count;
    } t_rsp;

    typedef struct {
        t_item it;
        int    rep;
        bit    typed;
        t_rsp  want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [ID_W-1:0]   i_cfg_wdata;

    pqm_req_if req_if();
    pqm_rsp_if rsp_if();

    process_queue_manager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the scheduler lists
    logic [ID_W-1:0]   next_pid [MAX_IDS];
    logic [ID_W-1:0]   prev_pid [MAX_IDS];
    logic [LIST_W-1:0] owner    [MAX_IDS];
    logic [ID_W-1:0]   head_of  [NUM_LISTS];
    logic [ID_W-1:0]   tail_of  [NUM_LISTS];
    bit                occupied [NUM_LISTS];
    logic [ID_W-1:0]   cur_pid;
    logic [ID_W-1:0]   idle_cfg;
    logic [ID_W-1:0]   last_pick;
    bit                after_next;
    int                id_next;
    int                n_linked;

    t_rsp pending_rsp[$];
    t_row dir_tab[$];
    int   mismatches  = 0;
    int   stall_token = 0;
    int   no_gap_left = 0;

    function automatic void clear_shadow();
        for (int i = 0; i < MAX_IDS; i++) begin
            next_pid[i] = '0;
            prev_pid[i] = '0;
            owner[i]    = LIST_NONE;
        end
        for (int l = 0; l < NUM_LISTS; l++) begin
            head_of[l]  = '0;
            tail_of[l]  = '0;
            occupied[l] = 1'b0;
        end
        cur_pid    = '0;
        idle_cfg   = '0;
        last_pick  = '0;
        after_next = 1'b0;
        id_next    = 0;
        n_linked   = 0;
    endfunction

    function automatic void link_at_tail(input logic [ID_W-1:0] p, input int l);
        if (occupied[l]) begin
            next_pid[tail_of[l]] = p;
            prev_pid[p]          = tail_of[l];
            tail_of[l]           = p;
        end else begin
            head_of[l]  = p;
            tail_of[l]  = p;
            occupied[l] = 1'b1;
        end
        owner[p] = LIST_W'(l);
        n_linked++;
    endfunction

    function automatic void drop_from_list(input logic [ID_W-1:0] p);
        int l;
        bit at_head;
        bit at_tail;
        l       = owner[p];
        at_head = (head_of[l] == p);
        at_tail = (tail_of[l] == p);
        if (at_head && at_tail) begin
            occupied[l] = 1'b0;
        end else if (at_head) begin
            head_of[l] = next_pid[p];
        end else if (at_tail) begin
            tail_of[l] = prev_pid[p];
        end else begin
            next_pid[prev_pid[p]] = next_pid[p];
            prev_pid[next_pid[p]] = prev_pid[p];
        end
        owner[p] = LIST_NONE;
        n_linked--;
    endfunction

    // Round robin over the exec list, falling back to the idle process
    function automatic logic [ID_W-1:0] next_runnable(input logic inc);
        if (cur_pid == idle_cfg || owner[cur_pid] != LIST_EXEC)
            return occupied[LIST_EXEC] ? head_of[LIST_EXEC] : idle_cfg;
        if (tail_of[LIST_EXEC] == cur_pid) begin
            if (head_of[LIST_EXEC] == cur_pid)
                return inc ? cur_pid : idle_cfg;
            return head_of[LIST_EXEC];
        end
        return next_pid[cur_pid];
    endfunction

    function automatic t_rsp apply_request(input t_item it);
        t_rsp r;
        r.result_id = it.pid;
        r.found     = 1'b0;
        r.list_of   = LIST_NONE;
        r.status    = ST_OK;
        after_next  = 1'b0;
        case (it.req)
            REQ_CREATE: begin
                if (id_next < MAX_IDS) begin
                    r.result_id = ID_W'(id_next);
                    id_next++;
                end else begin
                    r.result_id = '0;
                    r.status    = ST_BAD_ID;
                end
            end
            REQ_APPEND: begin
                if (it.sel >= NUM_LISTS)
                    r.status = ST_BAD_LIST;
                else if (owner[it.pid] != LIST_NONE)
                    r.status = ST_BAD_ID;
                else
                    link_at_tail(it.pid, it.sel);
            end
            REQ_UNLINK: begin
                if (owner[it.pid] == LIST_NONE)
                    r.status = ST_BAD_ID;
                else
                    drop_from_list(it.pid);
            end
            REQ_SETCUR: cur_pid = it.pid;
            REQ_NEXT: begin
                r.result_id = next_runnable(it.inc);
                last_pick   = r.result_id;
                after_next  = 1'b1;
            end
            REQ_LOOKUP: begin
                r.list_of = owner[it.pid];
                r.found   = (it.pid == idle_cfg) || (owner[it.pid] != LIST_NONE);
            end
            default: ;
        endcase
        r.proc_count = (n_linked > int'(ID_MAX)) ? ID_MAX : ID_W'(n_linked);
        return r;
    endfunction

    function automatic void find_id(input bit want_linked, output bit ok,
                                    output logic [ID_W-1:0] id);
        int start;
        start = $urandom_range(0, MAX_IDS - 1);
        ok    = 1'b0;
        id    = ID_W'(start);
        for (int k = 0; k < MAX_IDS; k++) begin
            if (!ok && ((owner[(start + k) % MAX_IDS] != LIST_NONE) == want_linked)) begin
                ok = 1'b1;
                id = ID_W'((start + k) % MAX_IDS);
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            no_gap_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    task automatic make_item(input t_mix mix, output t_item it);
        int c_app, c_unl, c_set, c_nxt, c_look, c_cre;
        int r, n, target, seen;
        bit ok;
        logic [ID_W-1:0] id;
        it.req = REQ_LOOKUP;
        it.pid = $urandom_range(0, MAX_IDS - 1);
        it.sel = $urandom_range(0, 7);
        it.inc = $urandom_range(0, 1);
        // Cumulative weights of append, unlink, set current, next, lookup, create
        case (mix)
            MIX_FILL:  begin c_app = 50; c_unl = 55; c_set = 65; c_nxt = 80; c_look = 92; c_cre = 97; end
            MIX_EMPTY: begin c_app = 8;  c_unl = 53; c_set = 63; c_nxt = 83; c_look = 93; c_cre = 97; end
            default:   begin c_app = 22; c_unl = 40; c_set = 52; c_nxt = 77; c_look = 90; c_cre = 96; end
        endcase
        // Usually switch to the process that next just chose
        if (after_next && $urandom_range(0, 9) < 7) begin
            it.req = REQ_SETCUR;
            it.pid = last_pick;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < c_app) begin
            it.req = REQ_APPEND;
            if ($urandom_range(0, 99) < 85) begin
                find_id(1'b0, ok, id);
                it.pid = id;
                it.sel = $urandom_range(0, 1) ? LIST_EXEC : LSEL_W'($urandom_range(1, 4));
            end else if ($urandom_range(0, 1)) begin
                it.sel = $urandom_range(LSEL_BAD_LO, LSEL_BAD_HI);
            end else begin
                find_id(1'b1, ok, id);
                it.pid = id;
                it.sel = $urandom_range(0, NUM_LISTS - 1);
            end
        end else if (r < c_unl) begin
            it.req = REQ_UNLINK;
            if ($urandom_range(0, 99) < 85) begin
                find_id(1'b1, ok, id);
                it.pid = id;
            end
        end else if (r < c_set) begin
            it.req = REQ_SETCUR;
            n = 0;
            for (int i = 0; i < MAX_IDS; i++)
                if (owner[i] == LIST_EXEC) n++;
            r = $urandom_range(0, 9);
            if (r < 7 && n > 0) begin
                target = $urandom_range(0, n - 1);
                seen   = 0;
                for (int i = 0; i < MAX_IDS; i++) begin
                    if (owner[i] == LIST_EXEC) begin
                        if (seen == target) it.pid = ID_W'(i);
                        seen++;
                    end
                end
            end else if (r == 7) begin
                it.pid = idle_cfg;
            end
        end else if (r < c_nxt) begin
            it.req = REQ_NEXT;
        end else if (r < c_look) begin
            r = $urandom_range(0, 9);
            if (r < 2) begin
                it.pid = idle_cfg;
            end else if (r < 5) begin
                find_id(1'b1, ok, id);
                it.pid = id;
            end
        end else if (r < c_cre) begin
            it.req = REQ_CREATE;
        end else begin
            it.req = $urandom_range(0, 1) ? REQ_UNDEF6 : REQ_UNDEF7;
        end
    endtask

    task automatic push(input t_item it, input int gap, input bit typed, input t_rsp want);
        t_rsp predicted;
        req_if.valid        <= 1'b1;
        req_if.req_type     <= it.req;
        req_if.proc_id      <= it.pid;
        req_if.list_sel     <= it.sel;
        req_if.include_self <= it.inc;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        predicted = apply_request(it);
        pending_rsp.push_back(typed ? want : predicted);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input t_mix mix, input int n_items);
        t_item it;
        t_rsp  none;
        none = '{default: '0};
        for (int i = 0; i < n_items; i++) begin
            make_item(mix, it);
            push(it, pick_gap(), 1'b0, none);
        end
    endtask

    // Hold the sender until every response is back
    task automatic drain();
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_idle(input logic [ID_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        idle_cfg  = v;
    endtask

    task automatic add_row(input logic [REQ_W-1:0] req, input logic [ID_W-1:0] pid,
                           input logic [LSEL_W-1:0] sel, input logic inc, input int rep,
                           input bit typed, input logic [ID_W-1:0] res, input logic fnd,
                           input logic [LIST_W-1:0] lst, input t_status st,
                           input logic [ID_W-1:0] cnt);
        t_row row;
        row.it    = '{req: req, pid: pid, sel: sel, inc: inc};
        row.rep   = rep;
        row.typed = typed;
        row.want  = '{result_id: res, found: fnd, list_of: lst, status: st, proc_count: cnt};
        dir_tab.push_back(row);
    endtask

    task automatic check_response();
        t_rsp want;
        if (pending_rsp.size() == 0) begin
            $error("unexpected transaction: result_id %0d status %0d",
                   rsp_if.result_id, rsp_if.status);
            mismatches++;
        end else begin
            want = pending_rsp.pop_front();
            if (rsp_if.result_id !== want.result_id) begin
                $error("result_id: expected %0d, got %0d", want.result_id, rsp_if.result_id);
                mismatches++;
            end
            if (rsp_if.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, rsp_if.found);
                mismatches++;
            end
            if (rsp_if.list_of !== want.list_of) begin
                $error("list_of: expected %0d, got %0d", want.list_of, rsp_if.list_of);
                mismatches++;
            end
            if (rsp_if.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                mismatches++;
            end
            if (rsp_if.proc_count !== want.proc_count) begin
                $error("proc_count: expected %0d, got %0d", want.proc_count, rsp_if.proc_count);
                mismatches++;
            end
        end
    endtask

    // Response side: check each transaction, then pick the next ready level
    initial begin
        int hold_left;
        int run_left;
        int stall_seen;
        int r;
        hold_left    = 0;
        run_left     = 0;
        stall_seen   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) check_response();
            if (stall_token != stall_seen) begin
                stall_seen = stall_token;
                hold_left  = HOLD_LEN;
                run_left   = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                rsp_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    run_left = $urandom_range(10, 80);
                    rsp_if.ready <= 1'b1;
                end else if (r < 75) begin
                    rsp_if.ready <= 1'b1;
                end else if (r < 95) begin
                    hold_left = $urandom_range(0, 2);
                    rsp_if.ready <= 1'b0;
                end else begin
                    hold_left = $urandom_range(10, 50);
                    rsp_if.ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_item it;
        t_rsp  none;
        none                = '{default: '0};
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_CREATE;
        req_if.proc_id      = '0;
        req_if.list_sel     = LIST_EXEC;
        req_if.include_self = 1'b0;
        clear_shadow();

        //      request     pid     list         inc rep chk res    fnd  list       status       count
        add_row(REQ_LOOKUP, 6'd0,  LIST_EXEC,   0,  1,  1,  6'd0,  1,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_LOOKUP, 6'd63, LSEL_BAD_HI, 1,  1,  1,  6'd63, 0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_NEXT,   6'd0,  LIST_EXEC,   0,  1,  1,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_CREATE, 6'd63, LIST_EXEC,   0,  1,  1,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_CREATE, 6'd0,  LIST_EXEC,   0,  63, 0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        // ids used up
        add_row(REQ_CREATE, 6'd21, LIST_EXEC,   1,  1,  1,  6'd0,  0,   LIST_NONE, ST_BAD_ID,   6'd0);
        add_row(REQ_APPEND, 6'd5,  LSEL_BAD_HI, 0,  1,  1,  6'd5,  0,   LIST_NONE, ST_BAD_LIST, 6'd0);
        add_row(REQ_APPEND, 6'd5,  LSEL_BAD_LO, 0,  1,  1,  6'd5,  0,   LIST_NONE, ST_BAD_LIST, 6'd0);
        add_row(REQ_UNLINK, 6'd9,  LIST_EXEC,   0,  1,  1,  6'd9,  0,   LIST_NONE, ST_BAD_ID,   6'd0);
        add_row(REQ_APPEND, 6'd63, LIST_EXEC,   0,  1,  1,  6'd63, 0,   LIST_NONE, ST_OK,       6'd1);
        add_row(REQ_APPEND, 6'd63, LIST_DELAY,  0,  1,  1,  6'd63, 0,   LIST_NONE, ST_BAD_ID,   6'd1);
        add_row(REQ_APPEND, 6'd1,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_APPEND, 6'd2,  LIST_TTYWR,  0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_APPEND, 6'd3,  LIST_DELAY,  0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_APPEND, 6'd4,  LIST_WAIT,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_APPEND, 6'd6,  LIST_TTYRD,  0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_LOOKUP, 6'd2,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_SETCUR, 6'd63, LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_NEXT,   6'd0,  LIST_EXEC,   1,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_SETCUR, 6'd1,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_NEXT,   6'd0,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        // current process sits outside the exec list
        add_row(REQ_SETCUR, 6'd3,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_NEXT,   6'd0,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        // lone current process, with and without include_self
        add_row(REQ_UNLINK, 6'd63, LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_SETCUR, 6'd1,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_NEXT,   6'd0,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_NEXT,   6'd0,  LIST_EXEC,   1,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_UNDEF6, 6'd63, LSEL_BAD_HI, 1,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_UNDEF7, 6'd42, LIST_TTYWR,  1,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        // empty exec list falls back to idle
        add_row(REQ_UNLINK, 6'd1,  LIST_EXEC,   0,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);
        add_row(REQ_NEXT,   6'd0,  LIST_EXEC,   1,  1,  0,  6'd0,  0,   LIST_NONE, ST_OK,       6'd0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_idle(6'd0);

        foreach (dir_tab[i])
            for (int k = 0; k < dir_tab[i].rep; k++)
                push(dir_tab[i].it, pick_gap(), dir_tab[i].typed, dir_tab[i].want);
        drain();

        write_idle(ID_MAX);
        run_phase(MIX_BALANCED, 500);
        drain();

        write_idle(ID_W'($urandom_range(1, 62)));
        run_phase(MIX_FILL, 400);

        // Back-pressure: receiver holds off while requests keep coming
        stall_token <= stall_token + 1;
        for (int i = 0; i < 30; i++) begin
            make_item(MIX_BALANCED, it);
            push(it, 0, 1'b0, none);
        end
        drain();

        write_idle(ID_W'($urandom_range(0, 63)));
        run_phase(MIX_EMPTY, 400);
        drain();

        write_idle(ID_W'($urandom_range(0, 63)));
        run_phase(MIX_BALANCED, 500);
        drain();
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
